@@ src/arb_pkg.sv @@
// Package for the arcball rotation block: types, constants and helper functions.
// No dependencies.
package arb_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned OpW = 2;
  localparam int unsigned AccW = 40;
  localparam int unsigned RootW = 32;

  // multiply-accumulate phase codes carried in cmd_t.mac_phase
  localparam logic [1:0] MAC_DELTA = 2'd1;
  localparam logic [1:0] MAC_PROD  = 2'd2;
  localparam logic [1:0] MAC_STORE = 2'd3;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_STORE,
    ST_DOT,
    ST_CROSS,
    ST_PROD,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       sqrt_start;
    logic       div_start;
    logic       div_sel_y;
    logic       store_start;
    logic       mac_start;
    logic [1:0] mac_phase;
    logic       out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic outside;
    logic busy;
  } status_t;

  // Q12.28 accumulator to Q2.14 with round half up and saturation
  function automatic logic signed [DataW-1:0] round_sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic signed [AccW-15:0] q;
    begin
      t = v + AccW'(8192);
      q = t[AccW-1:14];
      if (q > (AccW-14)'(32767)) round_sat = 16'sh7fff;
      else if (q < -(AccW-14)'(32768)) round_sat = 16'sh8000;
      else round_sat = q[DataW-1:0];
    end
  endfunction

endpackage

@@ src/arb_if.sv @@
// Valid/ready channel carrying one item of the arcball block.
// Depends on arb_pkg.
interface arb_in_if;
  logic valid;
  logic ready;
  logic [arb_pkg::OpW-1:0] opcode;
  logic signed [arb_pkg::DataW-1:0] cursor_x, cursor_y;
  logic signed [arb_pkg::DataW-1:0] orient_w, orient_x, orient_y, orient_z;
  modport source(output valid, opcode, cursor_x, cursor_y, orient_w, orient_x, orient_y,
                 orient_z, input ready);
  modport sink(input valid, opcode, cursor_x, cursor_y, orient_w, orient_x, orient_y,
               orient_z, output ready);
endinterface

interface arb_out_if;
  logic valid;
  logic ready;
  logic signed [arb_pkg::DataW-1:0] rot_w, rot_x, rot_y, rot_z;
  modport source(output valid, rot_w, rot_x, rot_y, rot_z, input ready);
  modport sink(input valid, rot_w, rot_x, rot_y, rot_z, output ready);
endinterface

@@ src/arcball_quaternion_rotation.sv @@
// Top level of the arcball rotation block: controller plus datapath.
// Depends on arb_pkg, arb_if, arb_ctrl and arb_datapath.
//
// Input channel items carry an opcode (press, release, tick), a Q2.14 cursor
// point and, for a press, the current orientation quaternion. The output
// channel carries one new orientation quaternion for each tick while dragging.
// Release and idle ops are handled in the idle state. A press runs the
// 32-step root and, outside the unit circle, two 46-step divides on the
// iterative units; a tick adds the delta and product passes on the single
// shared multiplier.
// One item is in work at a time; the result sits in an output register, so
// the next item is taken while a result waits, but a later tick waits in its
// final step until the earlier result is taken. Reset clears the drag flag,
// the stored start state and the output valid.
module arcball_quaternion_rotation (
  input logic clk,
  input logic rst,
  arb_in_if.sink   in_ch,
  arb_out_if.source out_ch
);
  arb_pkg::cmd_t cmd;
  arb_pkg::status_t status;

  arb_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.opcode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .status(status)
  );

  arb_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cursor_x(in_ch.cursor_x), .cursor_y(in_ch.cursor_y),
    .orient_w(in_ch.orient_w), .orient_x(in_ch.orient_x),
    .orient_y(in_ch.orient_y), .orient_z(in_ch.orient_z),
    .rot_w(out_ch.rot_w), .rot_x(out_ch.rot_x),
    .rot_y(out_ch.rot_y), .rot_z(out_ch.rot_z)
  );
endmodule

@@ src/arb_datapath.sv @@
// Datapath of the arcball block: sphere mapping (iterative root and divider),
// start state registers, and a shared multiply-accumulate. Depends on arb_pkg.
module arb_datapath (
  input  logic clk,
  input  logic rst,
  input  arb_pkg::cmd_t cmd,
  output arb_pkg::status_t status,
  input  logic signed [arb_pkg::DataW-1:0] cursor_x,
  input  logic signed [arb_pkg::DataW-1:0] cursor_y,
  input  logic signed [arb_pkg::DataW-1:0] orient_w,
  input  logic signed [arb_pkg::DataW-1:0] orient_x,
  input  logic signed [arb_pkg::DataW-1:0] orient_y,
  input  logic signed [arb_pkg::DataW-1:0] orient_z,
  output logic signed [arb_pkg::DataW-1:0] rot_w,
  output logic signed [arb_pkg::DataW-1:0] rot_x,
  output logic signed [arb_pkg::DataW-1:0] rot_y,
  output logic signed [arb_pkg::DataW-1:0] rot_z
);
  localparam int unsigned W = arb_pkg::DataW;
  localparam int unsigned A = arb_pkg::AccW;

  // captured item
  logic signed [W-1:0] px, py, ow, ox, oy, oz;
  logic outside;
  // current sphere vector and start state
  logic signed [W-1:0] cv [3];
  logic signed [W-1:0] sv [3];
  logic signed [W-1:0] so [4];
  logic signed [W-1:0] dq [4];

  // iterative root: 64-bit radicand, two bits per cycle
  logic [63:0] rad;
  logic [31:0] root;
  logic [33:0] rrem;
  logic [5:0]  rcnt;
  logic        rbusy;
  logic [33:0] trial;
  // iterative divider: 46/32, one bit per cycle
  logic [45:0] dnum;
  logic [32:0] drem;
  logic [45:0] dquo;
  logic [5:0]  dcnt;
  logic        dbusy;
  logic [32:0] dsh;
  logic [17:0] nq;
  // multiply-accumulate sequencer
  logic [3:0]  mcnt;
  logic        mbusy;
  logic [1:0]  mphase;
  logic signed [A-1:0] acc;
  logic signed [W-1:0] ma, mb;
  logic        msub;
  logic signed [2*W-1:0] mprod;
  logic signed [W-1:0] res [4];

  logic [31:0] sq_in;
  logic signed [W-1:0] sel_mag;

  assign trial = {rrem[31:0], rad[63:62]} - {root, 2'b01};
  assign dsh = {drem[31:0], dnum[45]};
  assign sel_mag = cmd.div_sel_y ? py : px;
  assign nq = dquo[18:1] + 18'(dquo[0]);
  assign status.outside = outside;
  assign status.busy = rbusy | dbusy | mbusy;
  assign sq_in = 32'(px * px) + 32'(py * py);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= cursor_x; py <= cursor_y;
      ow <= orient_w; ox <= orient_x; oy <= orient_y; oz <= orient_z;
    end
  end

  // outside flag and radicand are derived in the cycle after load (sqrt_start)
  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      outside <= sq_in >= 32'h1000_0000;
      rad <= (sq_in >= 32'h1000_0000) ? {sq_in, 32'd0} >> 4 : 64'(32'h1000_0000 - sq_in);
      root <= '0; rrem <= '0; rcnt <= 6'd32; rbusy <= 1'b1;
    end else if (rbusy) begin
      if (!trial[33]) begin
        rrem <= trial; root <= {root[30:0], 1'b1};
      end else begin
        rrem <= {rrem[31:0], rad[63:62]}; root <= {root[30:0], 1'b0};
      end
      rad <= {rad[61:0], 2'b00};
      rcnt <= rcnt - 6'd1;
      if (rcnt == 6'd1) rbusy <= 1'b0;
    end
  end

  // divider: (|v| << 29) / len, then round half away from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dnum <= {(sel_mag < 0 ? -17'(sel_mag) : 17'(sel_mag)), 29'd0};
      drem <= '0; dquo <= '0; dcnt <= 6'd46; dbusy <= 1'b1;
    end else if (dbusy) begin
      if (dsh >= {1'b0, root}) begin
        drem <= dsh - {1'b0, root}; dquo <= {dquo[44:0], 1'b1};
      end else begin
        drem <= dsh; dquo <= {dquo[44:0], 1'b0};
      end
      dnum <= {dnum[44:0], 1'b0};
      dcnt <= dcnt - 6'd1;
      if (dcnt == 6'd1) dbusy <= 1'b0;
    end
  end

  // sphere vector: inside keeps x, y and takes root as z; outside uses quotients
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      cv[0] <= px; cv[1] <= py; cv[2] <= '0;
    end else if (cmd.div_start && cmd.div_sel_y) begin
      cv[0] <= px < 0 ? -W'(nq) : W'(nq);
    end
    if (cmd.store_start && outside) cv[1] <= py < 0 ? -W'(nq) : W'(nq);
    if (cmd.store_start && !outside) cv[2] <= W'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= '0; sv[1] <= '0; sv[2] <= '0;
      so[0] <= '0; so[1] <= '0; so[2] <= '0; so[3] <= '0;
    end else if (cmd.out_load && cmd.mac_phase == arb_pkg::MAC_STORE) begin
      sv[0] <= cv[0]; sv[1] <= cv[1]; sv[2] <= cv[2];
      so[0] <= ow; so[1] <= ox; so[2] <= oy; so[3] <= oz;
    end
  end

  // MAC operand table: delta phase (4 outputs x 3 terms), product phase (4 x 4)
  always_comb begin
    ma = '0; mb = '0; msub = 1'b0;
    if (mphase == arb_pkg::MAC_DELTA) begin
      case (mcnt)
        4'd0:  begin ma = cv[0]; mb = sv[0]; end
        4'd1:  begin ma = cv[1]; mb = sv[1]; end
        4'd2:  begin ma = cv[2]; mb = sv[2]; end
        4'd3:  begin ma = cv[1]; mb = sv[2]; end
        4'd4:  begin ma = cv[2]; mb = sv[1]; msub = 1'b1; end
        4'd5:  begin ma = '0; mb = '0; end
        4'd6:  begin ma = cv[2]; mb = sv[0]; end
        4'd7:  begin ma = cv[0]; mb = sv[2]; msub = 1'b1; end
        4'd8:  begin ma = '0; mb = '0; end
        4'd9:  begin ma = cv[0]; mb = sv[1]; end
        4'd10: begin ma = cv[1]; mb = sv[0]; msub = 1'b1; end
        default: begin ma = '0; mb = '0; end
      endcase
    end else begin
      case (mcnt)
        4'd0:  begin ma = dq[0]; mb = so[0]; end
        4'd1:  begin ma = dq[1]; mb = so[1]; msub = 1'b1; end
        4'd2:  begin ma = dq[2]; mb = so[2]; msub = 1'b1; end
        4'd3:  begin ma = dq[3]; mb = so[3]; msub = 1'b1; end
        4'd4:  begin ma = dq[0]; mb = so[1]; end
        4'd5:  begin ma = dq[1]; mb = so[0]; end
        4'd6:  begin ma = dq[2]; mb = so[3]; end
        4'd7:  begin ma = dq[3]; mb = so[2]; msub = 1'b1; end
        4'd8:  begin ma = dq[0]; mb = so[2]; end
        4'd9:  begin ma = dq[1]; mb = so[3]; msub = 1'b1; end
        4'd10: begin ma = dq[2]; mb = so[0]; end
        4'd11: begin ma = dq[3]; mb = so[1]; end
        4'd12: begin ma = dq[0]; mb = so[3]; end
        4'd13: begin ma = dq[1]; mb = so[2]; end
        4'd14: begin ma = dq[2]; mb = so[1]; msub = 1'b1; end
        default: begin ma = dq[3]; mb = so[0]; end
      endcase
    end
  end

  assign mprod = ma * mb;

  // MAC sequencer: one product per cycle, group of 3 or 4 terms per result
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0; mphase <= arb_pkg::MAC_DELTA; mcnt <= '0; acc <= '0;
    end else if (cmd.mac_start) begin
      mbusy <= 1'b1; mphase <= cmd.mac_phase; mcnt <= '0; acc <= '0;
    end else if (mbusy) begin
      logic signed [A-1:0] nacc;
      logic last;
      logic [1:0] idx;
      nacc = msub ? acc - A'(mprod) : acc + A'(mprod);
      last = (mphase == arb_pkg::MAC_DELTA) ? (mcnt == 4'd2 || mcnt == 4'd5 ||
                                               mcnt == 4'd8 || mcnt == 4'd11)
                                            : (mcnt[1:0] == 2'd3);
      idx = (mphase == arb_pkg::MAC_DELTA) ? ((mcnt == 4'd2) ? 2'd0 : (mcnt == 4'd5) ? 2'd1 :
                                              (mcnt == 4'd8) ? 2'd2 : 2'd3) : mcnt[3:2];
      if (last) begin
        acc <= '0;
        if (mphase == arb_pkg::MAC_DELTA) dq[idx] <= arb_pkg::round_sat(nacc);
        else res[idx] <= arb_pkg::round_sat(nacc);
        if ((mphase == arb_pkg::MAC_DELTA && mcnt == 4'd11) ||
            (mphase != arb_pkg::MAC_DELTA && mcnt == 4'd15))
          mbusy <= 1'b0;
      end else begin
        acc <= nacc;
      end
      mcnt <= mcnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load && cmd.mac_phase == arb_pkg::MAC_PROD) begin
      rot_w <= res[0]; rot_x <= res[1]; rot_y <= res[2]; rot_z <= res[3];
    end
  end
endmodule

@@ src/arb_ctrl.sv @@
// Controller of the arcball block: sequences sphere mapping, storage and the
// quaternion product; owns the drag flag and the handshakes. Depends on arb_pkg.
module arb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [arb_pkg::OpW-1:0] opcode,
  output logic out_valid,
  input  logic out_ready,
  output arb_pkg::cmd_t cmd,
  input  arb_pkg::status_t status
);
  arb_pkg::state_t state, state_next;
  logic dragging, dragging_next;
  logic is_press, is_press_next;
  logic ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arb_pkg::ST_IDLE; dragging <= 1'b0; is_press <= 1'b0; ovalid <= 1'b0;
    end else begin
      state <= state_next; dragging <= dragging_next;
      is_press <= is_press_next; ovalid <= ovalid_next;
    end
  end

  assign out_valid = ovalid;

  always_comb begin
    state_next = state;
    dragging_next = dragging;
    is_press_next = is_press;
    ovalid_next = ovalid && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      arb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode)
            arb_pkg::OP_PRESS: begin
              cmd.load = 1'b1; is_press_next = 1'b1; state_next = arb_pkg::ST_SQRT;
            end
            arb_pkg::OP_RELEASE: dragging_next = 1'b0;
            arb_pkg::OP_TICK: begin
              if (dragging) begin
                cmd.load = 1'b1; is_press_next = 1'b0; state_next = arb_pkg::ST_SQRT;
              end
            end
            default: ;
          endcase
        end
      end
      arb_pkg::ST_SQRT: begin
        cmd.sqrt_start = 1'b1; state_next = arb_pkg::ST_DIVX;
      end
      arb_pkg::ST_DIVX: begin
        if (!status.busy) begin
          if (status.outside) begin
            cmd.div_start = 1'b1; state_next = arb_pkg::ST_DIVY;
          end else begin
            cmd.store_start = 1'b1; state_next = arb_pkg::ST_STORE;
          end
        end
      end
      arb_pkg::ST_DIVY: begin
        if (!status.busy) begin
          cmd.div_start = 1'b1; cmd.div_sel_y = 1'b1; state_next = arb_pkg::ST_DOT;
        end
      end
      arb_pkg::ST_DOT: begin
        if (!status.busy) begin
          cmd.store_start = 1'b1; state_next = arb_pkg::ST_STORE;
        end
      end
      arb_pkg::ST_STORE: begin
        if (is_press) begin
          cmd.out_load = 1'b1; cmd.mac_phase = arb_pkg::MAC_STORE;
          dragging_next = 1'b1; state_next = arb_pkg::ST_IDLE;
        end else begin
          cmd.mac_start = 1'b1; cmd.mac_phase = arb_pkg::MAC_DELTA;
          state_next = arb_pkg::ST_CROSS;
        end
      end
      arb_pkg::ST_CROSS: begin
        if (!status.busy) begin
          cmd.mac_start = 1'b1; cmd.mac_phase = arb_pkg::MAC_PROD;
          state_next = arb_pkg::ST_PROD;
        end
      end
      arb_pkg::ST_PROD: begin
        if (!status.busy) state_next = arb_pkg::ST_OUT;
      end
      arb_pkg::ST_OUT: begin
        if (!ovalid) begin
          cmd.out_load = 1'b1; cmd.mac_phase = arb_pkg::MAC_PROD;
          ovalid_next = 1'b1; state_next = arb_pkg::ST_IDLE;
        end
      end
      default: state_next = arb_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ src/arb_checker.sv @@
// Port-level checks for the arcball block, bound to the top level.
// Depends on arb_pkg and arb_if.
module arb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic [arb_pkg::OpW-1:0] opcode,
  input logic out_valid,
  input logic out_ready,
  input logic [4*arb_pkg::DataW-1:0] rot
);
  // held result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot)) else $error("result changed");
  // nothing valid right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after rst");
  // a release never produces a result next cycle
  a_rel: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == arb_pkg::OP_RELEASE && !out_valid |=> !out_valid)
    else $error("result after release");
  // a press blocks input the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == arb_pkg::OP_PRESS |=> !in_ready)
    else $error("press not sequenced");
endmodule

bind arcball_quaternion_rotation arb_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.opcode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .rot({out_ch.rot_w, out_ch.rot_x, out_ch.rot_y, out_ch.rot_z})
);
